// ===== src/pcfcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcfcs_pkg - shared definitions for the clock face column store
// constants, column unit command type and small arithmetic helpers
// ----------------------------------------------------------------------------
package pcfcs_pkg;

    // angle grid
    localparam int ANGLE_STEP   = 1;
    localparam int FULL_CIRCLE  = 360;
    localparam int COLUMNS      = FULL_CIRCLE / ANGLE_STEP;
    localparam int COL_W        = $clog2(COLUMNS);
    localparam int ANG_W        = 9;
    localparam int PAT_W        = 10;
    localparam int CNT_W        = 3;

    // degrees and face units
    localparam int DEG_PER_SEC  = 6;
    localparam int DEG_PER_HOUR = 30;
    localparam int HOURS_FACE   = 12;
    localparam int ARC_DEG      = 6;
    localparam int ARC_COUNT    = (ARC_DEG + ANGLE_STEP - 1) / ANGLE_STEP;

    // reciprocals for division by constants, 16 fraction bits
    localparam int RECIP_SHIFT  = 16;
    localparam int RECIP_STEP   = (2**RECIP_SHIFT + ANGLE_STEP - 1) / ANGLE_STEP;
    localparam int RECIP_SEC    = (2**RECIP_SHIFT + 10 * ANGLE_STEP - 1) / (10 * ANGLE_STEP);
    localparam int RECIP_MIN    = (2**RECIP_SHIFT + 2 * ANGLE_STEP - 1) / (2 * ANGLE_STEP);

    // led patterns
    localparam logic [PAT_W-1:0] PAT_CIRCLES  = 10'h101;
    localparam logic [PAT_W-1:0] PAT_MAJOR    = 10'h1C0;
    localparam logic [PAT_W-1:0] PAT_MINOR    = 10'h180;
    localparam logic [PAT_W-1:0] PAT_RING     = 10'h200;
    localparam logic [PAT_W-1:0] PAT_MIN_CLR  = 10'h01E;
    localparam logic [PAT_W-1:0] PAT_MIN_DRAW = 10'h01F;
    localparam logic [PAT_W-1:0] PAT_HR_CLR   = 10'h006;
    localparam logic [PAT_W-1:0] PAT_HR_DRAW  = 10'h007;

    typedef enum logic [1:0] {
        ACT_REDRAW = 2'd0,
        ACT_ARC    = 2'd1,
        ACT_HANDS  = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        K_WRITE,
        K_SET,
        K_CLR,
        K_READ
    } t_kind;

    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [COL_W-1:0] col;
        logic [PAT_W-1:0] pat;
    } t_col_cmd;

    // reduce an angle below twice the full circle
    function automatic logic [ANG_W-1:0] wrap360(input logic [ANG_W:0] a);
        if (a >= (ANG_W+1)'(FULL_CIRCLE)) begin
            return ANG_W'(a - (ANG_W+1)'(FULL_CIRCLE));
        end
        return a[ANG_W-1:0];
    endfunction

    // small value times reciprocal, integer part
    function automatic logic [5:0] div_small(input logic [5:0] v, input logic [16:0] recip);
        logic [22:0] p;
        p = 23'(v) * 23'(recip);
        return p[RECIP_SHIFT +: 6];
    endfunction

    // column index of an angle already below the full circle
    function automatic logic [COL_W-1:0] col_idx(input logic [ANG_W-1:0] a);
        logic [25:0] p;
        p = 26'(a) * 26'(RECIP_STEP);
        return p[RECIP_SHIFT +: COL_W];
    endfunction

endpackage

// ===== src/pcfcs_col_unit.sv =====
// ----------------------------------------------------------------------------
// pcfcs_col_unit - column memory with read-modify-write
// plain writes, set/clear of pattern bits and column reads
// ----------------------------------------------------------------------------
module pcfcs_col_unit
    import pcfcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_col_cmd         i_cmd,
    output logic [PAT_W-1:0] o_rd_data
);

    logic [PAT_W-1:0] r_mem [COLUMNS];
    logic [PAT_W-1:0] r_rd;
    logic [COL_W-1:0] r_col;
    logic [PAT_W-1:0] r_pat;
    logic             r_wb;
    logic             r_wb_set;

    logic             w_we;
    logic [COL_W-1:0] w_waddr;
    logic [PAT_W-1:0] w_wdata;

    // write-back of a pending modify has the port in its cycle
    always_comb begin
        w_we    = 1'b0;
        w_waddr = i_cmd.col;
        w_wdata = i_cmd.pat;
        if (r_wb) begin
            w_we    = 1'b1;
            w_waddr = r_col;
            w_wdata = r_wb_set ? (r_rd | r_pat) : (r_rd & ~r_pat);
        end else if (i_cmd.valid && i_cmd.kind == K_WRITE) begin
            w_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.valid && i_cmd.kind != K_WRITE) begin
            r_rd  <= r_mem[i_cmd.col];
            r_col <= i_cmd.col;
            r_pat <= i_cmd.pat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb     <= 1'b0;
            r_wb_set <= 1'b0;
        end else begin
            r_wb     <= i_cmd.valid && (i_cmd.kind == K_SET || i_cmd.kind == K_CLR);
            r_wb_set <= i_cmd.kind == K_SET;
        end
    end

    assign o_rd_data = r_rd;

endmodule

// ===== src/pov_clock_face_column_store.sv =====
// ----------------------------------------------------------------------------
// pov_clock_face_column_store - led column store for a rotating clock face
// redraw, seconds arc, hand moves and column reads under one sequencer
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake              | word
//  ---------+-----+------------------------+---------------------------------
//  s (cmd)  | in  | i_s_tvalid/o_s_tready  | action, hours, minutes, seconds,
//           |     |                        | column_angle
//  m (led)  | out | o_m_tvalid/i_m_tready  | led_pattern
//
//  every word goes through the single column read-modify-write unit: a read
//  reads one column, a hand move modifies four, a seconds arc ARC_COUNT, and
//  a redraw writes all COLUMNS columns and then moves the hands; every modify
//  reads and then writes back on the one memory port; after reset a clearing
//  pass writes zero to all COLUMNS entries; o_s_tready stays low until it ends
//  one word in flight; a read result waits in the output register, and a
//  following command is taken while it waits
//
module pov_clock_face_column_store
    import pcfcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // action[1:0], hours[5:2], minutes[11:6],
                                     // seconds[17:12], column_angle[26:18]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // led_pattern[9:0]
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_FILL,
        S_HANDS,
        S_ARC,
        S_READ,
        S_RDWAIT
    } t_state;

    t_state           r_state;

    // latched command
    t_action          r_action;
    logic [3:0]       r_h;
    logic [5:0]       r_m;
    logic [5:0]       r_s;
    logic [8:0]       r_ca;

    // angles in degrees
    logic [ANG_W-1:0] r_sa;
    logic [ANG_W-1:0] r_ma;
    logic [ANG_W-1:0] r_ha;
    logic [ANG_W-1:0] r_ca_ang;
    logic [ANG_W-1:0] r_arc_ang;
    logic [ANG_W-1:0] r_prev_min;
    logic [ANG_W-1:0] r_prev_hr;

    // sweep and step counters
    logic [COL_W-1:0] r_col;
    logic [ANG_W-1:0] r_ang_lo;
    logic [ANG_W-1:0] r_mark_ang;
    logic [1:0]       r_mark_ph;
    logic [CNT_W-1:0] r_cnt;
    logic             r_phase;

    // result register
    logic             r_out_valid;
    logic [PAT_W-1:0] r_out_data;

    t_col_cmd         w_cmd;
    logic [ANG_W-1:0] w_op_ang;
    logic [PAT_W-1:0] w_rd_data;
    logic [PAT_W-1:0] w_fill_pat;
    logic [ANG_W:0]   w_ang_hi;
    logic             w_mark_hit;
    logic [3:0]       w_h12;
    logic [ANG_W:0]   w_sa_raw;
    logic [ANG_W:0]   w_ma_raw;
    logic [ANG_W:0]   w_ha_raw;
    logic [ANG_W-1:0] w_arc_next;

    // angle arithmetic for the prep cycle
    always_comb begin
        w_h12    = (r_h >= 4'(HOURS_FACE)) ? 4'(r_h - 4'(HOURS_FACE)) : r_h;
        w_sa_raw = (ANG_W+1)'(r_s) * (ANG_W+1)'(DEG_PER_SEC);
        w_ma_raw = (ANG_W+1)'(r_m) * (ANG_W+1)'(DEG_PER_SEC)
                 + (ANG_W+1)'(div_small(r_s, 17'(RECIP_SEC)));
        w_ha_raw = (ANG_W+1)'(w_h12) * (ANG_W+1)'(DEG_PER_HOUR)
                 + (ANG_W+1)'(div_small(r_m, 17'(RECIP_MIN)));
    end

    // seconds arc walks backwards one step at a time, wrapping below zero
    assign w_arc_next = (r_arc_ang >= ANG_W'(ANGLE_STEP))
                      ? ANG_W'(r_arc_ang - ANG_W'(ANGLE_STEP))
                      : ANG_W'(r_arc_ang + ANG_W'(FULL_CIRCLE - ANGLE_STEP));

    // fill pattern of the current column: circles, hour mark, seconds ring
    always_comb begin
        w_ang_hi   = (ANG_W+1)'(r_ang_lo) + (ANG_W+1)'(ANGLE_STEP);
        w_mark_hit = (ANG_W+1)'(r_mark_ang) < w_ang_hi;
        w_fill_pat = PAT_CIRCLES;
        if (w_mark_hit) begin
            w_fill_pat = w_fill_pat | ((r_mark_ph == 2'd0) ? PAT_MAJOR : PAT_MINOR);
        end
        // odd minute lights the ring from the second angle to the end
        if (r_m[0] && ((ANG_W+1)'(r_sa) < w_ang_hi)) begin
            w_fill_pat = w_fill_pat | PAT_RING;
        end
    end

    // command to the column unit, one shared angle-to-column multiply
    always_comb begin
        w_op_ang    = r_ca_ang;
        w_cmd.valid = 1'b0;
        w_cmd.kind  = K_WRITE;
        w_cmd.pat   = '0;
        case (r_state)
            S_CLEAR: begin
                w_cmd.valid = 1'b1;
            end
            S_FILL: begin
                w_cmd.valid = 1'b1;
                w_cmd.pat   = w_fill_pat;
            end
            S_HANDS: begin
                w_cmd.valid = !r_phase;
                case (r_cnt[1:0])
                    2'd0: begin
                        w_op_ang   = r_prev_min;
                        w_cmd.kind = K_CLR;
                        w_cmd.pat  = PAT_MIN_CLR;
                    end
                    2'd1: begin
                        w_op_ang   = r_ma;
                        w_cmd.kind = K_SET;
                        w_cmd.pat  = PAT_MIN_DRAW;
                    end
                    2'd2: begin
                        w_op_ang   = r_prev_hr;
                        w_cmd.kind = K_CLR;
                        w_cmd.pat  = PAT_HR_CLR;
                    end
                    default: begin
                        w_op_ang   = r_ha;
                        w_cmd.kind = K_SET;
                        w_cmd.pat  = PAT_HR_DRAW;
                    end
                endcase
            end
            S_ARC: begin
                // odd minute clears the arc, even minute lights it
                w_cmd.valid = !r_phase;
                w_op_ang    = r_arc_ang;
                w_cmd.kind  = r_m[0] ? K_CLR : K_SET;
                w_cmd.pat   = PAT_RING;
            end
            S_READ: begin
                w_cmd.valid = 1'b1;
                w_cmd.kind  = K_READ;
            end
            default: begin
                w_cmd.valid = 1'b0;
            end
        endcase
        w_cmd.col = col_idx(w_op_ang);
        // sweeps address the column directly
        if (r_state == S_CLEAR || r_state == S_FILL) begin
            w_cmd.col = r_col;
        end
    end

    pcfcs_col_unit u_col_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_rd_data (w_rd_data)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_col       <= '0;
            r_cnt       <= '0;
            r_phase     <= 1'b0;
            r_prev_min  <= '0;
            r_prev_hr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the read wait state reloads the output register itself
            if (r_out_valid && i_m_tready && r_state != S_RDWAIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_col == COL_W'(COLUMNS - 1)) begin
                        r_col   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_col <= COL_W'(r_col + 1'b1);
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_action <= t_action'(i_s_tdata[1:0]);
                        r_h      <= i_s_tdata[5:2];
                        r_m      <= i_s_tdata[11:6];
                        r_s      <= i_s_tdata[17:12];
                        r_ca     <= i_s_tdata[26:18];
                        r_state  <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_sa       <= wrap360(w_sa_raw);
                    r_arc_ang  <= wrap360(w_sa_raw);
                    r_ma       <= wrap360(w_ma_raw);
                    r_ha       <= wrap360(w_ha_raw);
                    r_ca_ang   <= wrap360((ANG_W+1)'(r_ca));
                    r_col      <= '0;
                    r_ang_lo   <= '0;
                    r_mark_ang <= '0;
                    r_mark_ph  <= '0;
                    r_cnt      <= '0;
                    r_phase    <= 1'b0;
                    case (r_action)
                        ACT_REDRAW: r_state <= S_FILL;
                        ACT_ARC:    r_state <= S_ARC;
                        ACT_HANDS:  r_state <= S_HANDS;
                        default:    r_state <= S_READ;
                    endcase
                end
                S_FILL: begin
                    r_col    <= COL_W'(r_col + 1'b1);
                    r_ang_lo <= ANG_W'(w_ang_hi);
                    if (w_mark_hit) begin
                        r_mark_ang <= ANG_W'(r_mark_ang + ANG_W'(DEG_PER_HOUR));
                        r_mark_ph  <= (r_mark_ph == 2'd2) ? 2'd0 : 2'(r_mark_ph + 1'b1);
                    end
                    if (r_col == COL_W'(COLUMNS - 1)) begin
                        r_state <= S_HANDS;
                    end
                end
                S_HANDS: begin
                    r_phase <= !r_phase;
                    if (!r_phase) begin
                        if (r_cnt[1:0] == 2'd1) begin
                            r_prev_min <= r_ma;
                        end
                        if (r_cnt[1:0] == 2'd3) begin
                            r_prev_hr <= r_ha;
                        end
                    end else begin
                        r_cnt <= CNT_W'(r_cnt + 1'b1);
                        if (r_cnt == CNT_W'(3)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_ARC: begin
                    r_phase <= !r_phase;
                    if (!r_phase) begin
                        r_arc_ang <= w_arc_next;
                    end else begin
                        r_cnt <= CNT_W'(r_cnt + 1'b1);
                        if (r_cnt == CNT_W'(ARC_COUNT - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_RDWAIT;
                end
                S_RDWAIT: begin
                    // hold the read data until the output register is free
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= w_rd_data;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out_data};

endmodule

// ===== sim/tb_pov_clock_face_column_store.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pov_clock_face_column_store - self-checking bench for the led column store
// a local model of the clock face follows every accepted command word; each
// read word is checked against the led pattern that this model predicts
// ----------------------------------------------------------------------------
module tb_pov_clock_face_column_store;
    import pcfcs_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int SETTLE      = 10 + COLUMNS + 40;   // longest command, a redraw
    localparam int LIMIT       = 1000000;
    localparam int PHASE_WORDS = 400;

    // bench-side copies of the dut ports; the dut inputs are known from time zero
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // idle percentages of the sender and the receiver
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int cycle_count = 0;
    int errors      = 0;
    int reads_checked = 0;
    int words_sent  = 0;
    int words_by_action [4];

    // predicted face: one led pattern per column and the two hand angles
    logic [PAT_W-1:0] face_store [FULL_CIRCLE];
    int               last_min_hand;
    int               last_hour_hand;

    // led patterns still owed by the dut, oldest first
    logic [PAT_W-1:0] led_expect [$];
    logic [PAT_W-1:0] exp_led;

    pov_clock_face_column_store dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog on the cycle counter
    initial begin
        wait (cycle_count >= LIMIT);
        $display("%0t timeout after %0d cycles", $time, cycle_count);
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // face model
    // ------------------------------------------------------------------------

    // angle in degrees (never negative here) to column, reduced mod 360
    function automatic int column_of(input int angle);
        int c;
        c = (angle % FULL_CIRCLE) / ANGLE_STEP;
        return (c < FULL_CIRCLE) ? c : FULL_CIRCLE - 1;
    endfunction

    function automatic void light_bits(input logic [PAT_W-1:0] pat, input int angle);
        face_store[column_of(angle)] = face_store[column_of(angle)] | pat;
    endfunction

    function automatic void dark_bits(input logic [PAT_W-1:0] pat, input int angle);
        face_store[column_of(angle)] = face_store[column_of(angle)] & ~pat;
    endfunction

    // erase the old hands, draw the new ones; overlapping hands are not repaired
    function automatic void face_hands(input int hr, input int mn, input int sc);
        int min_angle;
        int hr_hand_deg;
        min_angle   = (mn * DEG_PER_SEC + sc / (10 * ANGLE_STEP)) % FULL_CIRCLE;
        hr_hand_deg = ((hr % HOURS_FACE) * DEG_PER_HOUR + mn / (2 * ANGLE_STEP)) % FULL_CIRCLE;
        dark_bits(PAT_MIN_CLR, last_min_hand);
        light_bits(PAT_MIN_DRAW, min_angle);
        last_min_hand = min_angle;
        dark_bits(PAT_HR_CLR, last_hour_hand);
        light_bits(PAT_HR_DRAW, hr_hand_deg);
        last_hour_hand = hr_hand_deg;
    endfunction

    function automatic void face_redraw(input int hr, input int mn, input int sc);
        int sec_angle;
        sec_angle = (sc * DEG_PER_SEC) % FULL_CIRCLE;
        for (int c = 0; c < COLUMNS; c++) face_store[c] = PAT_CIRCLES;
        for (int a = 0; a < FULL_CIRCLE; a += DEG_PER_HOUR) begin
            light_bits((a % 90 == 0) ? PAT_MAJOR : PAT_MINOR, a);
        end
        // odd minute: ring filled from the second hand on; even: emptied up to it
        if (mn % 2 == 1) begin
            for (int a = sec_angle; a < FULL_CIRCLE; a += ANGLE_STEP) light_bits(PAT_RING, a);
        end else begin
            for (int a = 0; a <= sec_angle; a += ANGLE_STEP) dark_bits(PAT_RING, a);
        end
        face_hands(hr, mn, sc);
    endfunction

    // one second's arc, walking backward from the second angle with wrap at zero
    function automatic void face_arc(input int mn, input int sc);
        int sec_angle;
        int a;
        sec_angle = (sc * DEG_PER_SEC) % FULL_CIRCLE;
        for (int i = 0; i < ARC_DEG; i += ANGLE_STEP) begin
            a = (sec_angle + FULL_CIRCLE - i) % FULL_CIRCLE;
            if (mn % 2 == 1) dark_bits(PAT_RING, a);
            else             light_bits(PAT_RING, a);
        end
    endfunction

    function automatic void face_apply(input t_action act, input int hr, input int mn,
                                       input int sc, input int ang);
        case (act)
            ACT_REDRAW: face_redraw(hr, mn, sc);
            ACT_ARC:    face_arc(mn, sc);
            ACT_HANDS:  face_hands(hr, mn, sc);
            default:    led_expect.push_back(face_store[column_of(ang)]);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus and response
    // ------------------------------------------------------------------------

    // send one command word; the model is updated at the accepting edge
    task automatic send_cmd(input t_action act, input logic [3:0] hr, input logic [5:0] mn,
                            input logic [5:0] sc, input logic [8:0] ang);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, ang, sc, mn, hr, act};
        do @(posedge clk); while (!s_tready);
        face_apply(act, hr, mn, sc, ang);
        words_sent++;
        words_by_action[act]++;
    endtask

    // hold the sender back until every read word has come back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (led_expect.size() != 0) @(posedge clk);
    endtask

    // receiver backpressure, redrawn every cycle
    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each delivered word with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (led_expect.size() == 0) begin
                errors++;
                $display("%0t unexpected word: expected none, actual led_pattern %03h",
                         $time, m_tdata[PAT_W-1:0]);
            end else begin
                exp_led = led_expect.pop_front();
                reads_checked++;
                if (m_tdata[PAT_W-1:0] !== exp_led) begin
                    errors++;
                    $display("%0t led_pattern mismatch: expected %03h, actual %03h",
                             $time, exp_led, m_tdata[PAT_W-1:0]);
                end
            end
        end
    end

    // read angle aimed at the interesting columns, out-of-range angles too
    function automatic logic [8:0] pick_angle(input logic [5:0] sc);
        case ($urandom_range(5))
            0:       return 9'($urandom_range(511));
            1:       return 9'(last_min_hand);
            2:       return 9'(last_hour_hand);
            3:       return 9'(((sc * DEG_PER_SEC) % FULL_CIRCLE + FULL_CIRCLE
                                - $urandom_range(7)) % FULL_CIRCLE);
            4:       return 9'(DEG_PER_HOUR * $urandom_range(11));
            default: return 9'(FULL_CIRCLE + $urandom_range(151));
        endcase
    endfunction

    // a ticking clock: redraw, then per second an arc, sometimes hands, and reads
    task automatic clock_burst();
        logic [3:0] hr;
        logic [5:0] mn;
        logic [5:0] sc;
        int         ticks;
        hr    = 4'($urandom_range(12));
        mn    = 6'($urandom_range(59));
        sc    = 6'($urandom_range(59));
        ticks = $urandom_range(4, 16);
        send_cmd(ACT_REDRAW, hr, mn, sc, 9'($urandom_range(511)));
        repeat (ticks) begin
            sc++;
            if (sc == 60) begin
                sc = 0;
                mn = (mn == 59) ? 6'd0 : mn + 6'd1;
                if (mn == 0) hr = (hr == 12) ? 4'd1 : hr + 4'd1;
            end
            send_cmd(ACT_ARC, hr, mn, sc, 9'($urandom_range(511)));
            if ($urandom_range(2) == 0) send_cmd(ACT_HANDS, hr, mn, sc, 9'($urandom_range(511)));
            repeat ($urandom_range(1, 3)) send_cmd(ACT_READ, hr, mn, sc, pick_angle(sc));
        end
    endtask

    // fully random word, every field over its whole width
    task automatic noise_word();
        t_action act;
        int      pick;
        pick = $urandom_range(19);
        act  = (pick == 0) ? ACT_REDRAW : (pick < 5) ? ACT_ARC : (pick < 9) ? ACT_HANDS : ACT_READ;
        send_cmd(act, 4'($urandom_range(15)), 6'($urandom_range(63)), 6'($urandom_range(63)),
                 9'($urandom_range(511)));
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // store comes out of the clearing pass all zero
    task automatic test_after_reset();
        send_cmd(ACT_READ, 0, 0, 0, 0);
        send_cmd(ACT_READ, 0, 0, 0, 359);
    endtask

    // full redraw: hour 12 as 0, marks, and out-of-range time with odd minute
    task automatic test_redraw();
        send_cmd(ACT_REDRAW, 12, 0, 0, 0);
        send_cmd(ACT_READ, 0, 0, 0, 0);
        send_cmd(ACT_READ, 0, 0, 0, 90);
        send_cmd(ACT_READ, 0, 0, 0, 30);
        send_cmd(ACT_REDRAW, 15, 63, 63, 511);
        send_cmd(ACT_READ, 0, 0, 0, 18);
        send_cmd(ACT_READ, 0, 0, 0, 17);
        send_cmd(ACT_READ, 0, 0, 0, 511);
    endtask

    // arc at second zero wraps below zero into the top columns
    task automatic test_seconds_arc();
        send_cmd(ACT_ARC, 0, 1, 0, 0);
        send_cmd(ACT_READ, 0, 0, 0, 357);
        send_cmd(ACT_ARC, 0, 2, 0, 0);
        send_cmd(ACT_READ, 0, 0, 0, 355);
        send_cmd(ACT_READ, 0, 0, 0, 354);
    endtask

    // overlapping hands, hands at the top of the range and past a full turn
    task automatic test_hands();
        send_cmd(ACT_HANDS, 0, 0, 0, 0);
        send_cmd(ACT_HANDS, 1, 5, 0, 0);
        send_cmd(ACT_READ, 0, 0, 0, 0);
        send_cmd(ACT_HANDS, 11, 59, 59, 0);
        send_cmd(ACT_READ, 0, 0, 0, 359);
        send_cmd(ACT_HANDS, 11, 63, 63, 0);
        send_cmd(ACT_READ, 0, 0, 0, 24);
        send_cmd(ACT_READ, 0, 0, 0, 1);
    endtask

    // random traffic under one idle setting, with one full drain halfway
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int start;
        bit drained;
        start         = words_sent;
        drained       = 1'b0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (words_sent - start < PHASE_WORDS) begin
            if ($urandom_range(4) != 0) clock_burst();
            else repeat ($urandom_range(1, 4)) noise_word();
            if (!drained && words_sent - start >= PHASE_WORDS / 2) begin
                drain_results();
                drained = 1'b1;
            end
        end
    endtask

    initial begin
        for (int c = 0; c < FULL_CIRCLE; c++) face_store[c] = '0;
        last_min_hand  = 0;
        last_hour_hand = 0;
        for (int a = 0; a < 4; a++) words_by_action[a] = 0;

        // reset held from time zero, released at a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 20;
        recv_idle_pct = 20;
        test_after_reset();
        test_redraw();
        test_seconds_arc();
        test_hands();

        test_random_traffic(30, 85);
        test_random_traffic(85, 30);
        test_random_traffic(0, 0);

        drain_results();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d words: %0d redraws, %0d arcs, %0d hand moves, %0d reads",
                 words_sent, words_by_action[ACT_REDRAW], words_by_action[ACT_ARC],
                 words_by_action[ACT_HANDS], words_by_action[ACT_READ]);
        $display("checked %0d led words over three idle settings in %0d cycles",
                 reads_checked, cycle_count);
        if (errors == 0 && led_expect.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
